[sv/shtl_pkg.sv]
// ----------------------------------------------------------------------------
// shtl_pkg
// Shared types and constants for the sorted hash table lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package shtl_pkg;

  // default table depth
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // fixed field widths
  localparam int KEY_W    = 64;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;

  // command codes carried in tuser
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[sv/sorted_hash_table_lookup.sv]
// Lookup: the bound search probes the table in S_SEARCH, S_CHECK compares the entry found
// (skipped when the bound lies past the last entry) and S_DONE loads the result beat.
// Insert: the same search, then S_SHIFT moves each larger entry up, S_PLACE writes the key and
// S_DONE loads the result; an insert into a full table skips to S_DONE. Flow: one beat in work
// at a time; in_tready returns as the result beat loads; a stalled result beat holds the block.
// Reset: entry count cleared to zero; the table memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_hash_table_lookup
// Keeps 64-bit hashes in ascending order in a table memory; inserts shift
// larger entries up, lookups return the leftmost matching index.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_hash_table_lookup #(
  parameter int TABLE_DEPTH = shtl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input beat
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [shtl_pkg::KEY_W-1:0] in_tdata,   // [63:0] hash_value
  input  wire logic                      in_tuser,    // [0] cmd
  // result beat
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [15:0]                    out_tdata,   // [9:0] position, [15:10] zero
  output logic [shtl_pkg::STATUS_W-1:0]  out_tuser    // [1:0] status
);

  import shtl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, at_r, at_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt, src_r, src_nxt;
  logic             pend_r, pend_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data, rd_data;

  logic             in_fire, out_free;
  logic [CNT_W-1:0] lo_c, hi_c, mid_ext, mid_sum, cnt_m1;
  logic [IDX_W-1:0] mid_c;
  logic             go_right, search_more, src_last;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_m1   = count_r - CNT_W'(1);
  assign src_last = (src_r == at_r[IDX_W-1:0]);

  // table memory
  shtl_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W),
    .DW    (KEY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // one step of the bound search, using the probe read last cycle
  always_comb begin
    lo_c     = lo_r;
    hi_c     = hi_r;
    go_right = 1'b0;
    mid_ext  = CNT_W'(mid_r);
    if (pend_r) begin
      go_right = (cmd_r == CMD_INSERT) ? (rd_data <= key_r) : (rd_data < key_r);
      if (go_right) begin
        lo_c = mid_ext + CNT_W'(1);
      end else begin
        hi_c = mid_ext;
      end
    end
    search_more = (lo_c < hi_c);
    mid_sum     = lo_c + ((hi_c - lo_c) >> 1);
    mid_c       = mid_sum[IDX_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == CMD_INSERT && count_r == DEPTH_C) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (!search_more) begin
          if (cmd_r == CMD_LOOKUP) begin
            state_nxt = (lo_c < count_r) ? S_CHECK : S_DONE;
          end else begin
            state_nxt = (count_r > lo_c) ? S_SHIFT : S_PLACE;
          end
        end
      end
      S_CHECK: state_nxt = S_DONE;
      S_SHIFT: begin
        if (src_last) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    at_nxt         = at_r;
    mid_nxt        = mid_r;
    src_nxt        = src_r;
    pend_nxt       = 1'b0;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    rd_en          = 1'b0;
    rd_addr        = mid_c;
    wr_en          = 1'b0;
    wr_addr        = src_r + IDX_W'(1);
    wr_data        = rd_data;
    in_tready      = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_tuser;
          key_nxt        = in_tdata;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          res_status_nxt = ST_FULL;
          res_pos_nxt    = '0;
        end
      end
      S_SEARCH: begin
        lo_nxt = lo_c;
        hi_nxt = hi_c;
        at_nxt = lo_c;
        if (search_more) begin
          rd_en    = 1'b1;
          rd_addr  = mid_c;
          mid_nxt  = mid_c;
          pend_nxt = 1'b1;
        end else if (cmd_r == CMD_LOOKUP) begin
          res_status_nxt = ST_MISS;
          res_pos_nxt    = '0;
          if (lo_c < count_r) begin
            rd_en   = 1'b1;
            rd_addr = lo_c[IDX_W-1:0];
          end
        end else if (count_r > lo_c) begin
          rd_en   = 1'b1;
          rd_addr = cnt_m1[IDX_W-1:0];
          src_nxt = cnt_m1[IDX_W-1:0];
        end
      end
      S_CHECK: begin
        if (rd_data == key_r) begin
          res_status_nxt = ST_HIT;
          res_pos_nxt    = POS_W'(at_r);
        end else begin
          res_status_nxt = ST_MISS;
          res_pos_nxt    = '0;
        end
      end
      S_SHIFT: begin
        // move entry src up one place, fetch the next lower one
        wr_en   = 1'b1;
        wr_addr = src_r + IDX_W'(1);
        wr_data = rd_data;
        if (!src_last) begin
          rd_en   = 1'b1;
          rd_addr = src_r - IDX_W'(1);
          src_nxt = src_r - IDX_W'(1);
        end
      end
      S_PLACE: begin
        wr_en          = 1'b1;
        wr_addr        = at_r[IDX_W-1:0];
        wr_data        = key_r;
        count_nxt      = count_r + CNT_W'(1);
        res_status_nxt = ST_INSERTED;
        res_pos_nxt    = POS_W'(at_r);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_pos_nxt    = res_pos_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(16 - POS_W){1'b0}}, out_pos_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    at_r         <= at_nxt;
    mid_r        <= mid_nxt;
    src_r        <= src_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  // entry count only ever grows by one, and only from the place step
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1)) && ($past(state_r) == S_PLACE))
    else $error("entry count changed outside an insert");

  // a full report only comes from a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (res_status_r == ST_FULL) |-> count_r == DEPTH_C)
    else $error("full status with room in table");

  // a hit never comes from an empty table
  a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && (res_status_r == ST_HIT) |-> count_r != '0)
    else $error("hit reported on empty table");

endmodule

`default_nettype wire

[sv/shtl_ram.sv]
// ----------------------------------------------------------------------------
// shtl_ram
// Simple dual-port table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module shtl_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the sorted hash table lookup block: drives insert and
// lookup beats with random idling on both sides, and checks every result beat
// against a table kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import shtl_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_PER_PHASE = 360;
  localparam int MAX_REPORTS = 10;
  localparam logic [KEY_W-1:0] HASH_MAX = '1;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
  } outcome_t;

  // scoreboard: sorted copy of the table plus outcomes still in flight
  class hash_lookup_checker;
    logic [KEY_W-1:0] entries [DEPTH];
    int unsigned      fill;
    outcome_t         expected_outcomes [$];
    int unsigned      mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // first index whose entry is >= key, or > key when past_equal is set
    function int unsigned find_bound(logic [KEY_W-1:0] key, bit past_equal);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = fill;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (past_equal ? (entries[mid] <= key) : (entries[mid] < key)) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    // update the table for an accepted input beat and queue its outcome
    function void note_item(logic cmd, logic [KEY_W-1:0] key);
      outcome_t    want;
      int unsigned at;
      want.status = ST_MISS;
      want.position = '0;
      if (cmd == CMD_INSERT) begin
        if (fill >= DEPTH) begin
          want.status = ST_FULL;
        end else begin
          at = find_bound(key, 1'b1);
          for (int unsigned i = fill; i > at; i--) entries[i] = entries[i-1];
          entries[at] = key;
          fill++;
          want.status = ST_INSERTED;
          want.position = at[POS_W-1:0];
        end
      end else begin
        at = find_bound(key, 1'b0);
        if (at < fill && entries[at] == key) begin
          want.status = ST_HIT;
          want.position = at[POS_W-1:0];
        end
      end
      expected_outcomes.push_back(want);
    endfunction

    // compare a result beat with the oldest pending outcome
    function void check_result(logic [STATUS_W-1:0] status, logic [15:0] data);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result beat with nothing pending: status %0d data 0x%04h",
                   $realtime, status, data);
        return;
      end
      want = expected_outcomes.pop_front();
      if (status !== want.status || data[POS_W-1:0] !== want.position ||
          data[15:POS_W] !== '0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: status exp %0d got %0d, position exp %0d got %0d (pad 0x%0h)",
                   $realtime, want.status, status, want.position, data[POS_W-1:0],
                   data[15:POS_W]);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [KEY_W-1:0]    in_tdata = '0;
  logic                in_tuser = CMD_INSERT;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [15:0]         out_tdata;
  logic [STATUS_W-1:0] out_tuser;

  int unsigned         send_idle_pct = 8;
  int unsigned         recv_idle_pct = 68;
  int unsigned         sent_fill = 0;
  logic [KEY_W-1:0]    inserted_hashes [$];

  hash_lookup_checker  lookup_chk = new();

  sorted_hash_table_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [63:0] hash_value
    .in_tuser   (in_tuser),    // [0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [9:0] position, [15:10] zero
    .out_tuser  (out_tuser)    // [1:0] status
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // random hash: mostly full width, some small or near the top for duplicates
  function automatic logic [KEY_W-1:0] random_hash();
    case ($urandom_range(9))
      0, 1: return KEY_W'($urandom_range(15));
      2: return HASH_MAX - KEY_W'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // lookup key: mostly stored hashes, some neighbors and some random
  function automatic logic [KEY_W-1:0] probe_hash();
    int unsigned      r;
    logic [KEY_W-1:0] stored;
    r = $urandom_range(99);
    if (inserted_hashes.size() == 0 || r < 25) return random_hash();
    stored = inserted_hashes[$urandom_range(inserted_hashes.size() - 1)];
    if (r < 35) return stored + 1'b1;
    if (r < 45) return stored - 1'b1;
    return stored;
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic cmd, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= key;
    do @(posedge clk); while (in_tready !== 1'b1);
    lookup_chk.note_item(cmd, key);
    if (cmd == CMD_INSERT && sent_fill < DEPTH) begin
      sent_fill++;
      inserted_hashes.push_back(key);
    end
  endtask

  // hold off the sender until every pending result beat is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (lookup_chk.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // random mix: mostly inserts with some repeats, lookups biased toward hits
  task automatic random_item();
    if ($urandom_range(99) < 90) begin
      if (inserted_hashes.size() > 0 && $urandom_range(99) < 15)
        send_beat(CMD_INSERT, inserted_hashes[$urandom_range(inserted_hashes.size() - 1)]);
      else
        send_beat(CMD_INSERT, random_hash());
    end else begin
      send_beat(CMD_LOOKUP, probe_hash());
    end
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) lookup_chk.check_result(out_tuser, out_tdata);
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table lookups miss
    send_beat(CMD_LOOKUP, '0);
    send_beat(CMD_LOOKUP, HASH_MAX);
    // extremes and duplicates, equal hashes land after their twins
    send_beat(CMD_INSERT, 64'd5);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_INSERT, HASH_MAX);
    send_beat(CMD_INSERT, 64'd5);
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_INSERT, HASH_MAX);
    send_beat(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_beat(CMD_INSERT, HASH_MAX - 1'b1);
    send_beat(CMD_INSERT, 64'd1);
    send_beat(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(CMD_INSERT, 64'h5555_5555_5555_5555);
    // leftmost hits and misses between entries
    send_beat(CMD_LOOKUP, '0);
    send_beat(CMD_LOOKUP, 64'd5);
    send_beat(CMD_LOOKUP, HASH_MAX);
    send_beat(CMD_LOOKUP, HASH_MAX - 1'b1);
    send_beat(CMD_LOOKUP, 64'd2);
    send_beat(CMD_LOOKUP, 64'h8000_0000_0000_0000);
    send_beat(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
    send_beat(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(CMD_LOOKUP, 64'h5555_5555_5555_5555);
    send_beat(CMD_LOOKUP, 64'd1);
    drain_results();

    // random phases: sender light idling, then receiver light, then none
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 8 : 0;
      repeat (RANDOM_PER_PHASE) begin
        random_item();
        if ($urandom_range(99) == 0) drain_results();
      end
      drain_results();
    end

    // fill to one short of full, then a top hash lands in the last slot
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent_fill < DEPTH - 1) begin
      if ($urandom_range(9) == 0) send_beat(CMD_LOOKUP, probe_hash());
      else send_beat(CMD_INSERT, random_hash());
    end
    send_beat(CMD_INSERT, HASH_MAX);

    // full table: inserts are dropped, lookups still work
    send_beat(CMD_INSERT, '0);
    send_beat(CMD_INSERT, HASH_MAX);
    repeat (4) send_beat(CMD_INSERT, random_hash());
    send_beat(CMD_LOOKUP, HASH_MAX);
    send_beat(CMD_LOOKUP, '0);
    repeat (20) send_beat(CMD_LOOKUP, probe_hash());

    drain_results();
    repeat (50) @(posedge clk);
    if (lookup_chk.mismatches == 0 && lookup_chk.expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
